@@ src/mclt_pkg.sv @@
// Package for the multi-channel logical timer.
// Command codes, transfer structs and controller state type; no dependencies.
`timescale 1ns / 1ps
`default_nettype none

package mclt_pkg;

	typedef enum logic [1:0] {
		CMD_TICK    = 2'd0,
		CMD_CREATE  = 2'd1,
		CMD_ENABLE  = 2'd2,
		CMD_DISABLE = 2'd3
	} cmd_t;

	typedef struct packed {
		cmd_t        command;
		logic [2:0]  timer_id;
		logic [15:0] period_ticks;
		logic        periodic;
	} in_t;

	typedef struct packed {
		logic       status;
		logic       expired;
		logic [2:0] expired_id;
		logic [3:0] running_count;
		logic       last;
	} out_t;

	typedef enum logic [1:0] {
		ST_IDLE,
		ST_SCAN,
		ST_DRAIN
	} state_t;

endpackage

`default_nettype wire

@@ src/mclt_ram.sv @@
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
`timescale 1ns / 1ps
`default_nettype none

module mclt_ram #(
	parameter int WIDTH = 32,
	parameter int DEPTH = 8
) (
	input  wire                                      clk,
	input  wire                                      we,
	input  wire [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr,
	input  wire [WIDTH-1:0]                          wdata,
	input  wire [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr,
	output logic [WIDTH-1:0]                         rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		rdata <= mem_q[raddr];
	end

endmodule

`default_nettype wire

@@ src/multi_channel_logical_timer_top.sv @@
// Top level of the multi-channel logical timer.
// Depends on mclt_pkg and mclt_ram.
`timescale 1ns / 1ps
`default_nettype none

// Multi-channel logical timer.
// Commands enter on item when start is high and busy is low. Each result
// appears on result for one cycle with strobe high; the receiver cannot
// stall, so results are never held.
// Create, enable and disable complete in the accept cycle; their single
// result follows in the next cycle and another command may be taken at once.
// A tick walks the timer RAM one entry a cycle: busy stays high through the
// SCAN state and the DRAIN state that ends the walk over the RAM.
// The walk is bounded by the single read port of the count RAM. Expiry
// results come out in index order during the walk, one per cycle; a tick
// with no expiry gives its one result in the cycle after acceptance.
// Ready, enabled, periodic and due marks live in flops; counts and reload
// values live in the RAM, which is only read for created timers and so
// needs no clearing after reset. Reset clears all marks and the running
// total; the block is ready for a command in the first cycle after reset.

module multi_channel_logical_timer_top #(
	parameter int TIMER_COUNT = 8,
	parameter int COUNT_WIDTH = 16
) (
	input  wire              clk,
	input  wire              arst_n,
	input  wire              start,
	output logic             busy,
	input  mclt_pkg::in_t    item,
	output logic             strobe,
	output mclt_pkg::out_t   result
);

	import mclt_pkg::*;

	localparam int IW = (TIMER_COUNT > 1) ? $clog2(TIMER_COUNT) : 1;
	localparam int TW = $clog2(TIMER_COUNT + 1);
	localparam int CW = COUNT_WIDTH;
	localparam logic [31:0] MAX_PERIOD = 32'((64'd1 << COUNT_WIDTH) - 64'd1);

	state_t state_q, state_d;

	logic [IW-1:0]          idx_q;
	logic [IW-1:0]          idx_s1;
	logic                   v_s1;
	logic [TIMER_COUNT-1:0] en_q, en_d;
	logic [TIMER_COUNT-1:0] rdy_q, rdy_d;
	logic [TIMER_COUNT-1:0] per_q, per_d;
	logic [TIMER_COUNT-1:0] due_q, due_d;
	logic [TIMER_COUNT-1:0] en_snap_q;
	logic [TIMER_COUNT-1:0] exp_snap_q;
	logic [TW-1:0]          total_q, total_d;
	out_t                   res_q, res_d;
	logic                   strobe_q, strobe_d;

	logic                   accept;
	logic                   id_ok;
	logic [IW-1:0]          id;
	logic [CW-1:0]          sat_period;
	logic [TIMER_COUNT-1:0] exp_mask;
	logic [TIMER_COUNT-1:0] oneshot_exp;
	logic [TW-1:0]          oneshot_cnt;
	logic [TIMER_COUNT-1:0] avail;
	logic [TIMER_COUNT-1:0] pick;
	logic [CW-1:0]          new_rem;

	logic                   ram_we;
	logic [IW-1:0]          ram_waddr;
	logic [2*CW-1:0]        ram_wdata;
	logic [IW-1:0]          ram_raddr;
	logic [2*CW-1:0]        ram_rdata;

	mclt_ram #(
		.WIDTH(2 * CW),
		.DEPTH(TIMER_COUNT)
	) u_count_ram (
		.clk  (clk),
		.we   (ram_we),
		.waddr(ram_waddr),
		.wdata(ram_wdata),
		.raddr(ram_raddr),
		.rdata(ram_rdata)
	);

	assign accept = start && !busy;
	assign id = IW'(item.timer_id);
	assign id_ok = (32'(item.timer_id) < TIMER_COUNT);
	assign sat_period = (32'(item.period_ticks) > MAX_PERIOD) ? CW'(MAX_PERIOD)
		: CW'(item.period_ticks);
	assign exp_mask = en_q & due_q;
	assign oneshot_exp = exp_mask & ~per_q;

	always_comb begin
		oneshot_cnt = '0;
		for (int i = 0; i < TIMER_COUNT; i++) begin
			oneshot_cnt = oneshot_cnt + TW'(oneshot_exp[i]);
		end
	end

	// next state
	always_comb begin
		state_d = state_q;
		unique case (state_q)
			ST_IDLE: begin
				if (accept && item.command == CMD_TICK) begin
					state_d = ST_SCAN;
				end
			end
			ST_SCAN: begin
				if (idx_q == IW'(TIMER_COUNT - 1)) begin
					state_d = ST_DRAIN;
				end
			end
			ST_DRAIN: begin
				state_d = ST_IDLE;
			end
			default: state_d = ST_IDLE;
		endcase
	end

	// controller outputs
	always_comb begin
		busy = (state_q != ST_IDLE);
		ram_raddr = idx_q;
	end

	// command execution and tick write-back
	always_comb begin
		en_d = en_q;
		rdy_d = rdy_q;
		per_d = per_q;
		due_d = due_q;
		total_d = total_q;
		res_d = '0;
		strobe_d = 1'b0;
		ram_we = 1'b0;
		ram_waddr = idx_s1;
		ram_wdata = '0;
		avail = '0;
		pick = '0;
		new_rem = ram_rdata[CW-1:0] - CW'(1);

		if (accept) begin
			res_d.last = 1'b1;
			if (item.command == CMD_TICK) begin
				en_d = en_q & ~oneshot_exp;
				total_d = total_q - oneshot_cnt;
				strobe_d = (exp_mask == '0);
			end else if (!id_ok) begin
				res_d.status = 1'b1;
				strobe_d = 1'b1;
			end else begin
				strobe_d = 1'b1;
				unique case (item.command)
					CMD_CREATE: begin
						if (en_q[id]) begin
							total_d = total_q - TW'(1);
						end
						en_d[id] = 1'b0;
						rdy_d[id] = 1'b1;
						per_d[id] = item.periodic;
						due_d[id] = (sat_period[CW-1:1] == '0);
						ram_we = 1'b1;
						ram_waddr = id;
						ram_wdata = {sat_period, sat_period};
					end
					CMD_ENABLE: begin
						if (rdy_q[id] && !en_q[id]) begin
							en_d[id] = 1'b1;
							total_d = total_q + TW'(1);
						end else begin
							res_d.status = 1'b1;
						end
					end
					CMD_DISABLE: begin
						en_d[id] = 1'b0;
						rdy_d[id] = 1'b0;
						avail = rdy_d & ~en_d;
						pick = avail & (~avail + TIMER_COUNT'(1));
						en_d = en_d | pick;
						total_d = total_q - TW'(en_q[id]) + TW'(pick != '0);
					end
					CMD_TICK: begin
					end
					default: begin
					end
				endcase
			end
		end

		if (v_s1 && en_snap_q[idx_s1]) begin
			ram_we = 1'b1;
			ram_waddr = idx_s1;
			if (exp_snap_q[idx_s1]) begin
				ram_wdata = {ram_rdata[2*CW-1:CW], ram_rdata[2*CW-1:CW]};
				due_d[idx_s1] = (ram_rdata[2*CW-1:CW+1] == '0);
				strobe_d = 1'b1;
				res_d.expired = 1'b1;
				res_d.expired_id = 3'(idx_s1);
				res_d.last = (((exp_snap_q >> idx_s1) >> 1) == '0);
			end else begin
				ram_wdata = {ram_rdata[2*CW-1:CW], new_rem};
				due_d[idx_s1] = (new_rem[CW-1:1] == '0);
			end
		end

		res_d.running_count = 4'(total_d);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			idx_q <= '0;
			v_s1 <= 1'b0;
			en_q <= '0;
			rdy_q <= '0;
			per_q <= '0;
			due_q <= '0;
			total_q <= '0;
			strobe_q <= 1'b0;
		end else begin
			state_q <= state_d;
			v_s1 <= (state_q == ST_SCAN);
			if (state_q == ST_SCAN) begin
				idx_q <= idx_q + IW'(1);
			end else begin
				idx_q <= '0;
			end
			en_q <= en_d;
			rdy_q <= rdy_d;
			per_q <= per_d;
			due_q <= due_d;
			total_q <= total_d;
			strobe_q <= strobe_d;
		end
	end

	always_ff @(posedge clk) begin
		idx_s1 <= idx_q;
		res_q <= res_d;
		if (accept && item.command == CMD_TICK) begin
			en_snap_q <= en_q;
			exp_snap_q <= exp_mask;
		end
	end

	assign strobe = strobe_q;
	assign result = res_q;

endmodule

`default_nettype wire

@@ test/mclt_checker.sv @@
// Result checker for the multi-channel logical timer.
// Keeps its own timer table, predicts every result and compares; depends on mclt_pkg.
`timescale 1ns / 1ps

module mclt_checker
	import mclt_pkg::*;
(
	input  wire   clk,
	input  wire   arst_n,
	input  wire   start,
	input  wire   busy,
	input  in_t   item,
	input  wire   strobe,
	input  out_t  result,
	output int    fail_count,
	output int    outstanding
);

	localparam int TIMERS = 8;

	logic [15:0]       count_left [TIMERS];
	logic [15:0]       reload_val [TIMERS];
	logic [TIMERS-1:0] periodic_m;
	logic [TIMERS-1:0] ready_m;
	logic [TIMERS-1:0] running_m;
	int                running_total;
	out_t              pending_q [$];
	int                errors = 0;
	int                queued = 0;

	assign fail_count  = errors;
	assign outstanding = queued;

	task automatic flag_mismatch(input string what);
		errors++;
		$display("mismatch at %0t ns: %s", $time, what);
	endtask

	task automatic compare_field(input string name, input int got, input int want);
		if (got != want) begin
			flag_mismatch($sformatf("%s got %0d want %0d", name, got, want));
		end
	endtask

	function automatic bit try_start(input int id);
		if (!ready_m[id] || running_m[id]) begin
			return 1'b0;
		end
		running_m[id] = 1'b1;
		running_total++;
		return 1'b1;
	endfunction

	task automatic predict_command(input in_t cmd);
		out_t batch [$];
		out_t r;
		int   i;
		int   id;
		r  = '0;
		id = int'(cmd.timer_id);
		if (cmd.command == CMD_TICK) begin
			for (i = 0; i < TIMERS; i++) begin
				if (running_m[i]) begin
					if (count_left[i] <= 16'd1) begin
						count_left[i] = reload_val[i];
						if (!periodic_m[i]) begin
							running_m[i] = 1'b0;
							running_total--;
						end
						r.expired    = 1'b1;
						r.expired_id = 3'(i);
						batch.push_back(r);
					end else begin
						count_left[i] = count_left[i] - 16'd1;
					end
				end
			end
			if (batch.size() == 0) begin
				batch.push_back(out_t'('0));
			end
		end else begin
			// 3-bit id always addresses a timer; 16-bit period never saturates
			case (cmd.command)
				CMD_CREATE: begin
					if (running_m[id]) begin
						running_total--;
					end
					running_m[id]  = 1'b0;
					ready_m[id]    = 1'b1;
					periodic_m[id] = cmd.periodic;
					reload_val[id] = cmd.period_ticks;
					count_left[id] = cmd.period_ticks;
				end
				CMD_ENABLE: begin
					r.status = !try_start(id);
				end
				CMD_DISABLE: begin
					if (running_m[id]) begin
						running_total--;
					end
					running_m[id] = 1'b0;
					ready_m[id]   = 1'b0;
					for (i = 0; i < TIMERS; i++) begin
						if (try_start(i)) begin
							break;
						end
					end
				end
				default: ;
			endcase
			batch.push_back(r);
		end
		foreach (batch[k]) begin
			batch[k].running_count = 4'(running_total);
			batch[k].last          = (k == batch.size() - 1);
			pending_q.push_back(batch[k]);
		end
	endtask

	always @(posedge clk or negedge arst_n) begin : watch
		out_t want;
		int   i;
		if (!arst_n) begin
			for (i = 0; i < TIMERS; i++) begin
				count_left[i] = '0;
				reload_val[i] = '0;
			end
			periodic_m    = '0;
			ready_m       = '0;
			running_m     = '0;
			running_total = 0;
			pending_q.delete();
			queued <= 0;
		end else begin
			if (strobe) begin
				if (pending_q.size() == 0) begin
					flag_mismatch("result with nothing expected");
				end else begin
					want = pending_q.pop_front();
					compare_field("status", int'(result.status), int'(want.status));
					compare_field("expired", int'(result.expired), int'(want.expired));
					compare_field("expired_id", int'(result.expired_id),
						int'(want.expired_id));
					compare_field("running_count", int'(result.running_count),
						int'(want.running_count));
					compare_field("last", int'(result.last), int'(want.last));
				end
			end
			if (start && !busy) begin
				predict_command(item);
			end
			queued <= pending_q.size();
		end
	end

endmodule

@@ test/tb_multi_channel_logical_timer_top.sv @@
// Testbench top for the multi-channel logical timer: stimulus, watchdog and verdict.
// Depends on mclt_pkg, multi_channel_logical_timer_top and mclt_checker.
`timescale 1ns / 1ps

module tb_multi_channel_logical_timer_top;
	import mclt_pkg::*;

	localparam int QUIET_LIMIT = 2000;
	localparam int RANDOM_ITEMS = 430;

	logic clk    = 1'b0;
	logic arst_n = 1'b0;
	logic start  = 1'b0;
	in_t  item   = '0;
	logic busy;
	logic strobe;
	out_t result;
	int   fail_count;
	int   outstanding;
	int   quiet = 0;

	always begin
		#2 clk = 1'b1;
		#2 clk = 1'b0;
	end

	multi_channel_logical_timer_top i_dut (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (start),
		.busy   (busy),
		.item   (item),
		.strobe (strobe),
		.result (result)
	);

	mclt_checker i_checker (
		.clk         (clk),
		.arst_n      (arst_n),
		.start       (start),
		.busy        (busy),
		.item        (item),
		.strobe      (strobe),
		.result      (result),
		.fail_count  (fail_count),
		.outstanding (outstanding)
	);

	always @(posedge clk) begin
		if ((start && !busy) || strobe) begin
			quiet <= 0;
		end else begin
			quiet <= quiet + 1;
		end
	end

	initial begin
		wait (quiet >= QUIET_LIMIT);
		$display("status: fail");
		$finish;
	end

	function automatic in_t make_cmd(input cmd_t c, input int id, input int ticks,
			input bit per);
		in_t cmd;
		cmd.command      = c;
		cmd.timer_id     = 3'(id);
		cmd.period_ticks = 16'(ticks);
		cmd.periodic     = per;
		return cmd;
	endfunction

	// start stays high from one transfer to the next unless a gap is taken
	task automatic issue_command(input in_t cmd, input bit allow_gap);
		if (allow_gap && $urandom_range(99) < 15) begin
			start <= 1'b0;
			repeat ($urandom_range(1, 12)) @(posedge clk);
		end
		item  <= cmd;
		start <= 1'b1;
		do @(posedge clk); while (busy);
	endtask

	initial begin
		in_t cmd;
		int  n;
		int  bucket;
		repeat (5) @(posedge clk);
		arst_n <= 1'b1;

		issue_command(make_cmd(CMD_TICK, 0, 0, 0), 1);
		issue_command(make_cmd(CMD_ENABLE, 0, 0, 0), 1);
		issue_command(make_cmd(CMD_DISABLE, 5, 0, 0), 1);
		issue_command(make_cmd(CMD_CREATE, 0, 0, 0), 1);
		issue_command(make_cmd(CMD_CREATE, 7, 65535, 1), 1);
		issue_command(make_cmd(CMD_CREATE, 3, 1, 1), 1);
		issue_command(make_cmd(CMD_ENABLE, 0, 0, 0), 1);
		issue_command(make_cmd(CMD_ENABLE, 0, 0, 0), 1);
		issue_command(make_cmd(CMD_TICK, 0, 0, 0), 1);
		issue_command(make_cmd(CMD_ENABLE, 3, 0, 0), 1);
		issue_command(make_cmd(CMD_ENABLE, 7, 0, 0), 1);
		issue_command(make_cmd(CMD_TICK, 0, 0, 0), 1);
		issue_command(make_cmd(CMD_CREATE, 3, 2, 0), 1);
		issue_command(make_cmd(CMD_DISABLE, 5, 0, 0), 1);
		issue_command(make_cmd(CMD_ENABLE, 3, 0, 0), 1);
		issue_command(make_cmd(CMD_TICK, 0, 0, 0), 1);
		issue_command(make_cmd(CMD_TICK, 0, 0, 0), 1);
		issue_command(make_cmd(CMD_DISABLE, 7, 0, 0), 1);
		issue_command(make_cmd(CMD_CREATE, 1, 16'h5555, 1), 1);
		issue_command(make_cmd(CMD_TICK, 7, 16'hAAAA, 1), 1);
		issue_command(make_cmd(CMD_CREATE, 2, 0, 1), 1);
		issue_command(make_cmd(CMD_ENABLE, 2, 0, 0), 1);
		issue_command(make_cmd(CMD_TICK, 0, 0, 0), 1);

		// mostly short periods so expiries pile up; no gaps in the middle stretch
		for (n = 0; n < RANDOM_ITEMS; n++) begin
			bucket       = $urandom_range(99);
			cmd.timer_id = 3'($urandom_range(7));
			cmd.periodic = 1'($urandom_range(1));
			if ($urandom_range(9) < 8) begin
				cmd.period_ticks = 16'($urandom_range(6));
			end else begin
				cmd.period_ticks = 16'($urandom);
			end
			if (bucket < 45) begin
				cmd.command = CMD_TICK;
			end else if (bucket < 65) begin
				cmd.command = CMD_CREATE;
			end else if (bucket < 85) begin
				cmd.command = CMD_ENABLE;
			end else begin
				cmd.command = CMD_DISABLE;
			end
			issue_command(cmd, n < 150 || n >= 280);
		end
		start <= 1'b0;

		@(posedge clk);
		while (outstanding != 0) @(posedge clk);
		repeat (24) @(posedge clk);
		if (fail_count == 0) begin
			$display("status: pass");
		end else begin
			$display("status: fail");
		end
		$finish;
	end

endmodule
